@@ rtl/core/fbq_pkg.sv @@
// shared types and constants for the framed byte queue
`timescale 1ns / 1ps

package fbq_pkg;

  localparam int TOKEN_BITS   = 64;
  localparam int PREFIX_BYTES = 2;

  localparam logic [7:0] THRESHOLD_RESET = 8'd1;
  localparam logic [7:0] COUNT_MAX       = 8'hFF;

  // register index as decoded from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_PUT_HDR  = 3'd2,
    REQ_TAKE_HDR = 3'd3,
    REQ_FLUSH    = 3'd4
  } fbq_req_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT_LEN,
    ST_PUT_DATA,
    ST_POP_CHECK,
    ST_POP_PREFIX,
    ST_POP_LEN,
    ST_POP_CALC,
    ST_POP_BYTE,
    ST_POP_OUT
  } fbq_state_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [7:0]            data_byte;
    logic [7:0]            record_length;
    logic                  record_end;
    logic [7:0]            read_capacity;
    logic [TOKEN_BITS-1:0] header_token;
  } fbq_req_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  byte_valid;
    logic                  record_done;
    logic                  record_end_flag;
    logic                  truncated;
    logic                  push_accepted;
    logic [TOKEN_BITS-1:0] header_out;
    logic                  header_out_valid;
    logic                  header_ready;
    logic                  data_ready;
    logic                  queue_empty;
  } fbq_res_t;

endpackage

@@ rtl/core/fbq_req_if.sv @@
// request channel interface
`timescale 1ns / 1ps

interface fbq_req_if;
  import fbq_pkg::*;

  logic     valid;
  logic     ready;
  fbq_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/fbq_res_if.sv @@
// result channel interface
`timescale 1ns / 1ps

interface fbq_res_if;
  import fbq_pkg::*;

  logic     valid;
  logic     ready;
  fbq_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/fbq_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fbq_ctrl.sv @@
// ring sequencer: record push/pop, excess skip, header slot, status
`timescale 1ns / 1ps

module fbq_ctrl #(
  parameter int QUEUE_BYTES = 2048,
  parameter int HEADER_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fbq_pkg::fbq_req_t req,
  input  logic [7:0]       threshold,
  output logic             busy,
  output logic             done,
  output fbq_pkg::fbq_res_t result
);
  import fbq_pkg::*;

  localparam int AW = $clog2(QUEUE_BYTES);
  localparam int FW = $clog2(QUEUE_BYTES + 1);
  localparam int WW = (FW > 8) ? FW : 8;

  fbq_state_t state, state_next;

  logic [AW-1:0]          wp, wp_next, rp, rp_next;
  logic [FW-1:0]          fill, fill_next;
  logic [7:0]             cnt, cnt_next;
  logic [HEADER_BITS-1:0] hdr, hdr_next;
  logic                   hdr_present, hdr_present_next;
  logic [7:0]             push_rem, push_rem_next;
  logic                   push_drop, push_drop_next;
  logic [7:0]             pop_rem, pop_rem_next;
  logic [7:0]             pop_exc, pop_exc_next;
  logic                   pop_active, pop_active_next;
  logic                   pop_end, pop_end_next;
  logic                   pop_trunc, pop_trunc_next;
  logic [7:0]             lat_len, lat_len_next;
  logic [7:0]             lat_data, lat_data_next;
  logic [7:0]             lat_cap, lat_cap_next;

  // ring port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // pointer steps
  logic [AW:0]   wp_sum, rp_sum;
  logic [AW-1:0] wp_inc, rp_inc;

  // excess skip
  logic [7:0]    skip_exc_in, skip_exc_out;
  logic [WW-1:0] skip_k;
  logic [WW:0]   skip_rp_sum;
  logic [AW-1:0] skip_rp;
  logic [FW-1:0] skip_fill;

  // first pop of a record
  logic [7:0] calc_deliver, calc_exc;
  logic       calc_trunc;

  logic [WW+1:0] space_sum;
  logic          space_over;
  logic          count_ok;

  fbq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  always_comb begin
    wp_sum = {1'b0, wp} + (AW+1)'(1);
    rp_sum = {1'b0, rp} + (AW+1)'(1);
    wp_inc = (wp_sum == (AW+1)'(QUEUE_BYTES)) ? '0 : wp_sum[AW-1:0];
    rp_inc = (rp_sum == (AW+1)'(QUEUE_BYTES)) ? '0 : rp_sum[AW-1:0];

    calc_deliver = (ram_rdata < lat_cap) ? ram_rdata : lat_cap;
    calc_exc     = ram_rdata - calc_deliver;
    calc_trunc   = ram_rdata > lat_cap;

    // skip as many excess bytes as are present
    skip_exc_in  = (state == ST_POP_CALC) ? calc_exc : pop_exc;
    skip_k       = (WW'(skip_exc_in) < WW'(fill)) ? WW'(skip_exc_in) : WW'(fill);
    skip_rp_sum  = (WW+1)'(rp) + (WW+1)'(skip_k);
    if (skip_rp_sum >= (WW+1)'(QUEUE_BYTES)) begin
      skip_rp_sum = skip_rp_sum - (WW+1)'(QUEUE_BYTES);
    end
    skip_rp      = skip_rp_sum[AW-1:0];
    skip_fill    = fill - FW'(skip_k);
    skip_exc_out = skip_exc_in - 8'(skip_k);

    space_sum  = (WW+2)'(fill) + (WW+2)'(req.record_length) + (WW+2)'(PREFIX_BYTES);
    space_over = space_sum > (WW+2)'(QUEUE_BYTES);
  end

  always_comb begin
    state_next       = state;
    wp_next          = wp;
    rp_next          = rp;
    fill_next        = fill;
    cnt_next         = cnt;
    hdr_next         = hdr;
    hdr_present_next = hdr_present;
    push_rem_next    = push_rem;
    push_drop_next   = push_drop;
    pop_rem_next     = pop_rem;
    pop_exc_next     = pop_exc;
    pop_active_next  = pop_active;
    pop_end_next     = pop_end;
    pop_trunc_next   = pop_trunc;
    lat_len_next     = lat_len;
    lat_data_next    = lat_data;
    lat_cap_next     = lat_cap;
    ram_we           = 1'b0;
    ram_waddr        = wp;
    ram_wdata        = lat_data;
    done             = 1'b0;
    result           = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          lat_len_next  = req.record_length;
          lat_data_next = req.data_byte;
          lat_cap_next  = req.read_capacity;
          case (req.req_type)
            REQ_PUSH: begin
              if (push_rem == 8'd0) begin
                push_rem_next = (req.record_length != 8'd0) ?
                                req.record_length - 8'd1 : 8'd0;
                if (space_over) begin
                  push_drop_next = req.record_length > 8'd1;
                  done           = 1'b1;
                end else begin
                  ram_we         = 1'b1;
                  ram_wdata      = {7'd0, req.record_end};
                  wp_next        = wp_inc;
                  fill_next      = fill + FW'(1);
                  push_drop_next = 1'b0;
                  if (req.record_end) begin
                    cnt_next = threshold;
                  end else if (cnt != COUNT_MAX) begin
                    cnt_next = cnt + 8'd1;
                  end
                  state_next = ST_PUT_LEN;
                end
              end else begin
                push_rem_next = push_rem - 8'd1;
                done          = 1'b1;
                if (push_drop) begin
                  if (push_rem == 8'd1) begin
                    push_drop_next = 1'b0;
                  end
                end else if (fill < FW'(QUEUE_BYTES)) begin
                  ram_we               = 1'b1;
                  ram_wdata            = req.data_byte;
                  wp_next              = wp_inc;
                  fill_next            = fill + FW'(1);
                  result.push_accepted = 1'b1;
                end
              end
            end
            REQ_POP: begin
              state_next = ST_POP_CHECK;
            end
            REQ_PUT_HDR: begin
              hdr_next         = req.header_token[HEADER_BITS-1:0];
              hdr_present_next = 1'b1;
              done             = 1'b1;
            end
            REQ_TAKE_HDR: begin
              if (hdr_present) begin
                result.header_out       = TOKEN_BITS'(hdr);
                result.header_out_valid = 1'b1;
              end
              hdr_present_next = 1'b0;
              done             = 1'b1;
            end
            REQ_FLUSH: begin
              wp_next          = '0;
              rp_next          = '0;
              fill_next        = '0;
              cnt_next         = '0;
              hdr_next         = '0;
              hdr_present_next = 1'b0;
              push_rem_next    = '0;
              push_drop_next   = 1'b0;
              pop_rem_next     = '0;
              pop_exc_next     = '0;
              pop_active_next  = 1'b0;
              pop_end_next     = 1'b0;
              pop_trunc_next   = 1'b0;
              done             = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_PUT_LEN: begin
        ram_we    = 1'b1;
        ram_wdata = lat_len;
        wp_next   = wp_inc;
        fill_next = fill + FW'(1);
        if (lat_len == 8'd0) begin
          result.push_accepted = 1'b1;
          done                 = 1'b1;
          state_next           = ST_IDLE;
        end else begin
          state_next = ST_PUT_DATA;
        end
      end

      ST_PUT_DATA: begin
        ram_we               = 1'b1;
        ram_wdata            = lat_data;
        wp_next              = wp_inc;
        fill_next            = fill + FW'(1);
        result.push_accepted = 1'b1;
        done                 = 1'b1;
        state_next           = ST_IDLE;
      end

      ST_POP_CHECK: begin
        if (pop_active && pop_rem == 8'd0) begin
          rp_next      = skip_rp;
          fill_next    = skip_fill;
          pop_exc_next = skip_exc_out;
          if (skip_exc_out != 8'd0) begin
            // still waiting for excess bytes
            result.record_end_flag = pop_end;
            result.truncated       = pop_trunc;
            done                   = 1'b1;
            state_next             = ST_IDLE;
          end else begin
            pop_active_next = 1'b0;
            state_next      = ST_POP_PREFIX;
          end
        end else if (pop_active) begin
          state_next = ST_POP_BYTE;
        end else begin
          state_next = ST_POP_PREFIX;
        end
      end

      ST_POP_PREFIX: begin
        if (fill < FW'(PREFIX_BYTES)) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          rp_next    = rp_inc;
          fill_next  = fill - FW'(1);
          state_next = ST_POP_LEN;
        end
      end

      ST_POP_LEN: begin
        pop_end_next = ram_rdata == 8'd1;
        rp_next      = rp_inc;
        fill_next    = fill - FW'(1);
        state_next   = ST_POP_CALC;
      end

      ST_POP_CALC: begin
        pop_rem_next    = calc_deliver;
        pop_trunc_next  = calc_trunc;
        pop_active_next = 1'b1;
        if (calc_deliver == 8'd0) begin
          rp_next                = skip_rp;
          fill_next              = skip_fill;
          pop_exc_next           = skip_exc_out;
          pop_active_next        = skip_exc_out != 8'd0;
          result.record_done     = 1'b1;
          result.record_end_flag = pop_end;
          result.truncated       = calc_trunc;
          done                   = 1'b1;
          state_next             = ST_IDLE;
        end else begin
          pop_exc_next = calc_exc;
          state_next   = ST_POP_BYTE;
        end
      end

      ST_POP_BYTE: begin
        if (fill == '0) begin
          // byte not pushed yet
          result.record_end_flag = pop_end;
          result.truncated       = pop_trunc;
          done                   = 1'b1;
          state_next             = ST_IDLE;
        end else begin
          rp_next      = rp_inc;
          fill_next    = fill - FW'(1);
          pop_rem_next = pop_rem - 8'd1;
          state_next   = ST_POP_OUT;
        end
      end

      ST_POP_OUT: begin
        result.out_byte        = ram_rdata;
        result.byte_valid      = 1'b1;
        result.record_end_flag = pop_end;
        result.truncated       = pop_trunc;
        if (pop_rem == 8'd0) begin
          result.record_done = 1'b1;
          rp_next            = skip_rp;
          fill_next          = skip_fill;
          pop_exc_next       = skip_exc_out;
          pop_active_next    = skip_exc_out != 8'd0;
        end
        done       = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    count_ok            = cnt_next >= threshold;
    result.header_ready = hdr_present_next && count_ok;
    result.data_ready   = !hdr_present_next && count_ok;
    result.queue_empty  = !hdr_present_next && (fill_next == '0);
  end

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wp          <= '0;
      rp          <= '0;
      fill        <= '0;
      cnt         <= '0;
      hdr_present <= 1'b0;
      push_rem    <= '0;
      push_drop   <= 1'b0;
      pop_rem     <= '0;
      pop_exc     <= '0;
      pop_active  <= 1'b0;
      pop_end     <= 1'b0;
      pop_trunc   <= 1'b0;
    end else begin
      state       <= state_next;
      wp          <= wp_next;
      rp          <= rp_next;
      fill        <= fill_next;
      cnt         <= cnt_next;
      hdr_present <= hdr_present_next;
      push_rem    <= push_rem_next;
      push_drop   <= push_drop_next;
      pop_rem     <= pop_rem_next;
      pop_exc     <= pop_exc_next;
      pop_active  <= pop_active_next;
      pop_end     <= pop_end_next;
      pop_trunc   <= pop_trunc_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr      <= hdr_next;
    lat_len  <= lat_len_next;
    lat_data <= lat_data_next;
    lat_cap  <= lat_cap_next;
  end

endmodule

@@ rtl/core/framed_byte_queue_threshold_unit.sv @@
// top level of the framed byte queue with release threshold
`timescale 1ns / 1ps

// Framed byte queue: records of up to 255 bytes, each kept in a byte ring behind a
// two-byte prefix (end flag, length), plus one header token slot.
// req channel (valid/ready): one request per transaction - push byte, pop byte,
// put header, take header or flush; codes 5 to 7 only report status.
// res channel (valid/ready): exactly one result transaction per request, in order.
// APB port: register 0 (paddr 0) is release_threshold, reset value 1; write it
// only while no request is outstanding. pready is tied high.
// Request to result runs through the sequencer states; the ring memory has one
// write port and one read port with registered read data:
//   header ops, flush, follow-on push and dropped push: answered from idle
//   first push of a record: end flag, then length (then the data byte)
//   pop that only discards excess: check; pop on an empty ring: check, prefix
//   pop inside a record: check, byte, out (check, byte if the byte is missing)
//   pop that opens a record: check, prefix, length, calc (then byte, out)
// A new request is taken once the previous one finishes and the result frees up.
// The result sits in an output register; a stalled receiver holds it and
// blocks new requests until taken. Reset clears the ring pointers, counters and
// the header slot; ring contents are not cleared and need no clearing pass.

module framed_byte_queue_threshold_unit #(
  parameter int QUEUE_BYTES = 2048,
  parameter int HEADER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  fbq_req_if.sink     req,
  fbq_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbq_pkg::*;

  logic [7:0] threshold;
  logic       cfg_write;

  logic     ctl_start;
  logic     ctl_busy;
  logic     ctl_done;
  fbq_res_t ctl_result;

  // output register
  fbq_res_t res_q;
  logic     res_valid;

  // config register, written in the apb access phase
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_THRESHOLD) ? {24'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= pwdata[7:0];
    end
  end

  // take a request only when the sequencer is idle and the result slot frees up
  assign req.ready = !ctl_busy && (!res_valid || res.ready);
  assign ctl_start = req.valid && req.ready;

  fbq_ctrl #(
    .QUEUE_BYTES (QUEUE_BYTES),
    .HEADER_BITS (HEADER_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl_start),
    .req       (req.payload),
    .threshold (threshold),
    .busy      (ctl_busy),
    .done      (ctl_done),
    .result    (ctl_result)
  );

  // result register: a finished transaction loads it, the receiver drains it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl_done) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_done) begin
      res_q <= ctl_result;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_q;

`ifndef NO_ASSERTIONS
  // a finished transaction never overwrites an undelivered result
  assert property (@(posedge clk) disable iff (rst)
    ctl_done |-> (!res_valid || res.ready))
    else $error("result register overrun");

  // header-ready and data-ready are never reported together
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.payload.header_ready && res.payload.data_ready))
    else $error("header_ready and data_ready both set");

  // a flush is answered next cycle with an empty queue
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.payload.req_type == REQ_FLUSH)
      |=> (res.valid && res.payload.queue_empty))
    else $error("flush did not empty the queue");

  // a stored header is answered next cycle and makes the queue non-empty
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.payload.req_type == REQ_PUT_HDR)
      |=> (res.valid && !res.payload.queue_empty && !res.payload.data_ready))
    else $error("put header status wrong");
`endif

endmodule

@@ bench/tb_framed_byte_queue_threshold_unit.sv @@
// self-checking testbench for the framed byte queue with release threshold
`timescale 1ns / 1ps

module tb_framed_byte_queue_threshold_unit;
  import fbq_pkg::*;

  // ring size of the instance under test
  localparam int QUEUE_BYTES = 2048;

  // request codes that the block only answers with status
  localparam logic [2:0] REQ_CODE_UNUSED_MIN = 3'd5;
  localparam logic [2:0] REQ_CODE_MAX        = 3'd7;

  // byte address of the threshold register on the config port
  localparam logic [2:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

  // short settle pause once every outstanding result has come back
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int RX_HOLD_LEN  = 200;

  // generous wall for the whole run, several times the slowest legal run
  localparam longint TIMEOUT_NS = 5_000_000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fbq_req_if req_ch ();
  fbq_res_if res_ch ();

  framed_byte_queue_threshold_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------
  // shadow state of the queue; the ring is kept as a byte queue, so the
  // fill level is simply its size and the pointers are implicit
  // ---------------------------------------------------------------------
  logic [7:0]  ring_model[$];
  logic [7:0]  rec_count_model;
  logic [63:0] hdr_slot_model;
  logic        hdr_held;
  logic [7:0]  push_left;      // data bytes still owed by the record being pushed
  logic        push_skip;      // record being pushed did not fit and is dropped
  logic [7:0]  pop_left;       // bytes still to deliver from the record being popped
  logic [7:0]  pop_skip;       // bytes beyond the reader capacity still to discard
  logic        pop_busy;
  logic        pop_end_flag;
  logic        pop_trunc_flag;
  logic [7:0]  threshold_model;

  // results predicted for accepted requests, oldest first
  fbq_res_t    pending_results[$];

  int          mismatch_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_cycles;

  // ---------------------------------------------------------------------
  // clock and limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // queue model
  // ---------------------------------------------------------------------
  function automatic void clear_queue_model();
    ring_model.delete();
    rec_count_model = '0;
    hdr_slot_model  = '0;
    hdr_held        = 1'b0;
    push_left       = '0;
    push_skip       = 1'b0;
    pop_left        = '0;
    pop_skip        = '0;
    pop_busy        = 1'b0;
    pop_end_flag    = 1'b0;
    pop_trunc_flag  = 1'b0;
  endfunction

  // throw away excess bytes of a truncated record as far as they have arrived
  function automatic void discard_excess_bytes();
    while (pop_skip != 8'd0 && ring_model.size() != 0) begin
      void'(ring_model.pop_front());
      pop_skip = pop_skip - 8'd1;
    end
    if (pop_skip == 8'd0 && pop_left == 8'd0) begin
      pop_busy = 1'b0;
    end
  endfunction

  function automatic fbq_res_t predict_queue_response(input fbq_req_t r);
    fbq_res_t   o;
    logic [7:0] len;
    logic [7:0] cap;
    logic [7:0] deliver;
    logic       served;
    logic       count_ok;
    o = '0;
    served = 1'b0;
    case (r.req_type)
      REQ_PUSH: begin
        if (push_left == 8'd0) begin
          // first transaction of a record carries length and end flag
          len = r.record_length;
          if (ring_model.size() + int'(len) + PREFIX_BYTES > QUEUE_BYTES) begin
            push_left = (len != 8'd0) ? len - 8'd1 : 8'd0;
            push_skip = (push_left != 8'd0);
          end else begin
            ring_model.push_back({7'd0, r.record_end});
            ring_model.push_back(len);
            if (r.record_end) begin
              rec_count_model = threshold_model;
            end else if (rec_count_model != COUNT_MAX) begin
              rec_count_model = rec_count_model + 8'd1;
            end
            if (len != 8'd0) begin
              ring_model.push_back(r.data_byte);
              push_left = len - 8'd1;
            end
            push_skip = 1'b0;
            o.push_accepted = 1'b1;
          end
        end else begin
          push_left = push_left - 8'd1;
          if (push_skip) begin
            if (push_left == 8'd0) begin
              push_skip = 1'b0;
            end
          end else if (ring_model.size() < QUEUE_BYTES) begin
            ring_model.push_back(r.data_byte);
            o.push_accepted = 1'b1;
          end
        end
      end
      REQ_POP: begin
        // all data delivered but excess still awaited: discard only
        if (pop_busy && pop_left == 8'd0) begin
          discard_excess_bytes();
          if (pop_busy) begin
            o.record_end_flag = pop_end_flag;
            o.truncated       = pop_trunc_flag;
            served = 1'b1;
          end
        end
        if (!served && !pop_busy) begin
          if (ring_model.size() < PREFIX_BYTES) begin
            served = 1'b1;
          end else begin
            // open the next record from its prefix
            pop_end_flag   = (ring_model.pop_front() == 8'd1);
            len            = ring_model.pop_front();
            cap            = r.read_capacity;
            deliver        = (len < cap) ? len : cap;
            pop_skip       = len - deliver;
            pop_left       = deliver;
            pop_trunc_flag = (len > cap);
            pop_busy       = 1'b1;
            if (deliver == 8'd0) begin
              o.record_done = 1'b1;
              discard_excess_bytes();
              o.record_end_flag = pop_end_flag;
              o.truncated       = pop_trunc_flag;
              served = 1'b1;
            end
          end
        end
        if (!served) begin
          o.record_end_flag = pop_end_flag;
          o.truncated       = pop_trunc_flag;
          // a byte not yet pushed leaves the pop stalled with flags only
          if (ring_model.size() != 0) begin
            o.out_byte   = ring_model.pop_front();
            o.byte_valid = 1'b1;
            pop_left     = pop_left - 8'd1;
            if (pop_left == 8'd0) begin
              o.record_done = 1'b1;
              discard_excess_bytes();
            end
          end
        end
      end
      REQ_PUT_HDR: begin
        hdr_slot_model = r.header_token;
        hdr_held       = 1'b1;
      end
      REQ_TAKE_HDR: begin
        if (hdr_held) begin
          o.header_out       = hdr_slot_model;
          o.header_out_valid = 1'b1;
        end
        hdr_held = 1'b0;
      end
      REQ_FLUSH: begin
        clear_queue_model();
      end
      default: begin
      end
    endcase
    // a zero threshold makes the count condition always true
    count_ok       = (rec_count_model >= threshold_model);
    o.header_ready = hdr_held && count_ok;
    o.data_ready   = !hdr_held && count_ok;
    o.queue_empty  = !hdr_held && (ring_model.size() == 0);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // reporting
  // ---------------------------------------------------------------------
  function automatic string describe_result(input fbq_res_t v);
    return $sformatf({"byte=%02h bv=%b done=%b end=%b trunc=%b acc=%b ",
                      "hdr=%016h hv=%b hr=%b dr=%b em=%b"},
                     v.out_byte, v.byte_valid, v.record_done, v.record_end_flag,
                     v.truncated, v.push_accepted, v.header_out, v.header_out_valid,
                     v.header_ready, v.data_ready, v.queue_empty);
  endfunction

  task automatic log_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random ready, long hold-off on demand, in-order check
  // ---------------------------------------------------------------------
  initial begin : result_side
    fbq_res_t want;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      // values read here are those sampled at this edge
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          log_failure($sformatf("result with nothing outstanding: %s",
                                describe_result(res_ch.payload)));
        end else begin
          want = pending_results.pop_front();
          if (res_ch.payload !== want) begin
            log_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                  describe_result(want), describe_result(res_ch.payload)));
          end
        end
      end
      // hold-off is counted down here, independent of the sender
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles = rx_hold_cycles - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // offer one request, optionally after an idle gap; valid stays high on
  // return so that back-to-back transactions need no second assignment
  task automatic send_req(input fbq_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_results.push_back(predict_queue_response(r));
  endtask

  task automatic send_op(input logic [2:0] code, input logic [7:0] data,
                         input logic [7:0] len, input logic rec_end,
                         input logic [7:0] cap, input logic [63:0] token);
    fbq_req_t r;
    r.req_type      = code;
    r.data_byte     = data;
    r.record_length = len;
    r.record_end    = rec_end;
    r.read_capacity = cap;
    r.header_token  = token;
    send_req(r);
  endtask

  // stop offering, wait for every outstanding result, then let the block settle
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write of the threshold, then a read back of the same register
  task automatic write_release_threshold(input logic [7:0] value);
    wait_for_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    threshold_model = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[7:0] !== value) begin
      log_failure($sformatf("threshold read back %02h, wrote %02h", prdata[7:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // hand-picked transactions: empty queue, header slot, zero-length record,
  // stalled pop, truncation with late excess, unused codes, flush
  task automatic test_directed();
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd255, '0);   // pop on empty
    send_op(REQ_TAKE_HDR, 8'h00, 8'd0,   1'b0, 8'd0,   '0);   // no header stored
    send_op(REQ_PUT_HDR,  8'h00, 8'd0,   1'b0, 8'd0,   '1);
    send_op(REQ_TAKE_HDR, 8'h00, 8'd0,   1'b0, 8'd0,   '0);
    send_op(REQ_PUT_HDR,  8'h00, 8'd0,   1'b0, 8'd0,   '0);
    // prefix-only record, data byte must be ignored
    send_op(REQ_PUSH,     8'hFF, 8'd0,   1'b1, 8'd0,   '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd0,   '0);
    // three-byte record, popped faster than it is pushed
    send_op(REQ_PUSH,     8'hFF, 8'd3,   1'b0, 8'd0,   '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd255, '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd255, '0);   // byte not there yet
    send_op(REQ_PUSH,     8'h00, 8'd3,   1'b0, 8'd0,   '0);
    send_op(REQ_PUSH,     8'hA5, 8'd3,   1'b0, 8'd0,   '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd255, '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd255, '0);
    // four-byte end record read with capacity one, excess arrives later
    send_op(REQ_PUSH,     8'h01, 8'd4,   1'b1, 8'd0,   '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd1,   '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd1,   '0);   // discard only
    send_op(REQ_PUSH,     8'h02, 8'd4,   1'b1, 8'd0,   '0);
    send_op(REQ_PUSH,     8'h03, 8'd4,   1'b1, 8'd0,   '0);
    send_op(REQ_PUSH,     8'h04, 8'd4,   1'b1, 8'd0,   '0);
    send_op(REQ_POP,      8'h00, 8'd0,   1'b0, 8'd1,   '0);
    send_op(REQ_CODE_UNUSED_MIN, 8'h00, 8'd0, 1'b0, 8'd0, '0);
    send_op(REQ_CODE_MAX, 8'h00, 8'd0,   1'b0, 8'd0,   '0);
    send_op(REQ_FLUSH,    8'h00, 8'd0,   1'b0, 8'd0,   '0);
    send_op(REQ_TAKE_HDR, 8'h00, 8'd0,   1'b0, 8'd0,   '0);
  endtask

  // mostly well-formed record traffic with random content, plus flushes,
  // unused codes and pops that run ahead of the writer
  task automatic test_random_traffic(input int n_items);
    fbq_req_t r;
    int       k;
    repeat (n_items) begin
      r.data_byte    = 8'($urandom);
      r.record_end   = 1'($urandom_range(1));
      r.header_token = {$urandom, $urandom};
      r.read_capacity = ($urandom_range(3) == 0) ? 8'($urandom_range(8))
                                                 : 8'($urandom_range(255));
      // short records most of the time, now and then a long one
      k = $urandom_range(99);
      r.record_length = (k < 3)  ? 8'($urandom_range(255)) :
                        (k < 12) ? 8'($urandom_range(40))  : 8'($urandom_range(8));
      k = $urandom_range(99);
      if (k < 2) begin
        r.req_type = REQ_FLUSH;
      end else if (k < 4) begin
        r.req_type = 3'($urandom_range(REQ_CODE_MAX, REQ_CODE_UNUSED_MIN));
      end else if (k < 10) begin
        r.req_type = REQ_PUT_HDR;
      end else if (k < 16) begin
        r.req_type = REQ_TAKE_HDR;
      end else if (k < 58) begin
        r.req_type = REQ_PUSH;
      end else begin
        r.req_type = REQ_POP;
      end
      send_req(r);
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_stall();
    rx_hold_cycles = RX_HOLD_LEN;
    test_random_traffic(40);
  endtask

  // fill the ring to the last byte with one-byte records and a prefix-only
  // record, hit the no-space drop for zero-length, one-byte and longer
  // records, then read everything back
  task automatic test_fill_and_drop();
    int n_short;
    n_short = QUEUE_BYTES / (PREFIX_BYTES + 1);
    send_op(REQ_FLUSH, 8'h00, 8'd0, 1'b0, 8'd0, '0);
    for (int i = 0; i < n_short; i++) begin
      send_op(REQ_PUSH, 8'($urandom), 8'd1, 1'($urandom_range(1)), 8'd0, '0);
    end
    // the last two bytes take a prefix-only record
    send_op(REQ_PUSH, 8'($urandom), 8'd0, 1'b0, 8'd0, '0);
    // no room left for any record
    send_op(REQ_PUSH, 8'($urandom), 8'd0, 1'b1, 8'd0, '0);
    send_op(REQ_PUSH, 8'($urandom), 8'd1, 1'b0, 8'd0, '0);
    for (int j = 0; j < 3; j++) begin
      send_op(REQ_PUSH, 8'($urandom), 8'd3, 1'b1, 8'd0, '0);
    end
    while (ring_model.size() != 0 || pop_busy) begin
      send_op(REQ_POP, 8'h00, 8'd0, 1'b0, 8'd255, '0);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    rx_hold_cycles = 0;
    tx_idle_pct    = 35;
    rx_idle_pct    = 82;
    threshold_model = THRESHOLD_RESET;
    clear_queue_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the threshold in force here
    test_directed();

    // sender idles little, receiver a lot
    write_release_threshold(8'd255);
    test_random_traffic(300);

    // the other way round, with the always-true zero threshold
    write_release_threshold(8'd0);
    tx_idle_pct = 82;
    rx_idle_pct = 35;
    test_random_traffic(300);

    write_release_threshold(8'($urandom_range(254, 2)));
    tx_idle_pct = 0;
    test_output_stall();

    // no idling from here on
    write_release_threshold(8'd1);
    rx_idle_pct = 0;
    test_fill_and_drop();
    test_random_traffic(100);

    wait_for_drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
